FILE: sv/obbsa_pkg.sv
// ----------------------------------------------------------------------------
// obbsa_pkg: shared types and helpers for the box overlap tester
// Command codes, the tag that rides beside the shared multiplier, and the
// rounding and clamping helpers for Q.28 to Q.14 conversion.
// ----------------------------------------------------------------------------
package obbsa_pkg;

	localparam int QW = 16;                 // quaternion and axis entry width
	localparam int UB_W = 18;               // multiplier B operand width
	localparam int ENT_W = 34;              // Q.28 intermediate width
	localparam int RND_W = 21;              // rounded Q.14 width before clamp
	localparam int ABS_W = 17;              // magnitude of a rounded dot product
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;
	localparam logic signed [QW-1:0] AXIS_MAX = 16'sd16384;
	localparam logic signed [ENT_W-1:0] ONE_Q28 = 34'sd268435456;

	// what the product in flight is used for
	typedef enum logic [1:0] {
		K_QP,
		K_DOT,
		K_HALF,
		K_OFF
	} kind_t;

	typedef struct packed {
		logic  vld;
		kind_t kind;
		logic [3:0] idx;
		logic  first;
		logic  last;
	} tag_t;

	// Q.28 -> Q.14, round half up (floor after adding one half)
	function automatic logic signed [RND_W-1:0] rnd14(input logic signed [ENT_W-1:0] v);
		logic signed [ENT_W:0] t;
		t = (ENT_W+1)'(v) + 35'sd8192;
		return t[ENT_W:14];
	endfunction

	// saturate a rounded entry to [-1, 1] in Q1.14
	function automatic logic signed [QW-1:0] clamp16(input logic signed [RND_W-1:0] r);
		if (r > 21'sd16384)
			return AXIS_MAX;
		if (r < -21'sd16384)
			return -AXIS_MAX;
		return r[QW-1:0];
	endfunction

endpackage

FILE: sv/obb_overlap_separating_axis.sv
// ----------------------------------------------------------------------------
// obb_overlap_separating_axis: oriented box overlap, face-axis separating test
// Loads a reference box and tests target boxes against it, one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel: req_valid/req_stall with cmd, center, half and rot fields.
//  cmd = load writes the reference box when accepted and gives no result.
//  cmd = test starts a sequence on the shared multiplier: it first builds
//  both rotation matrices, then each of the six face axes runs axis fetch,
//  projections, half terms, offset and compare, in that order.
//  A test that overlaps runs all six axes before its result; an axis that
//  separates ends the test early. Loads go one per cycle while idle; the
//  shared multiplier takes one product per cycle. req_stall is high while
//  a test is running.
//  Result channel: res_valid/res_stall with overlap. The result sits in an
//  output register; a stalled result holds, and a new test waits at its
//  final compare until that register is free, with requests stalled.
//  Reset: reference box becomes a zero-size box at the origin with identity
//  orientation; no result pending.
// ----------------------------------------------------------------------------
module obb_overlap_separating_axis #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic [COORD_WIDTH-2:0]        half_x,
	input  logic [COORD_WIDTH-2:0]        half_y,
	input  logic [COORD_WIDTH-2:0]        half_z,
	input  logic signed [15:0]            rot_w,
	input  logic signed [15:0]            rot_x,
	input  logic signed [15:0]            rot_y,
	input  logic signed [15:0]            rot_z,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          overlap
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = CW + 2;
	localparam int PW = AW + obbsa_pkg::UB_W;
	localparam int QW = obbsa_pkg::QW;
	localparam int EW = obbsa_pkg::ENT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QP,
		S_EN,
		S_ULD,
		S_DOT,
		S_HALF,
		S_OFF,
		S_CMP
	} state_t;

	state_t state_q;
	logic [3:0] cnt_q;
	logic [1:0] sub_q;
	logic       box_q;
	logic [2:0] axis_q;
	logic       res_valid_q;
	logic       overlap_q;

	logic signed [CW-1:0] rc_q [3];
	logic [CW-2:0]        rh_q [3];
	logic signed [QW-1:0] rq_q [4];
	logic signed [CW-1:0] tc_q [3];
	logic [CW-2:0]        th_q [3];
	logic signed [QW-1:0] tq_q [4];

	logic signed [31:0]   qp_q [9];
	logic signed [QW-1:0] ax_q [18];
	logic signed [QW-1:0] u_q [3];
	logic [obbsa_pkg::ABS_W-1:0] absd_q [6];
	logic signed [EW-1:0] dacc_q;
	logic [PW-1:0]        halves_q;
	logic signed [PW-1:0] off_q;

	logic req_acc;
	logic res_acc;
	logic signed [AW-1:0] mul_a;
	logic signed [obbsa_pkg::UB_W-1:0] mul_b;
	obbsa_pkg::tag_t tag_in;
	obbsa_pkg::tag_t tag_s1;
	logic signed [PW-1:0] p_s1;

	logic signed [QW-1:0] qw, qx, qy, qz, qa, qb;
	logic signed [EW-1:0] ent [9];
	logic signed [QW-1:0] ax_wr;
	logic [4:0]           ax_ridx;
	logic [4:0]           ax_widx;
	logic signed [QW-1:0] ax_rd;
	logic [CW-2:0]        h_sel;
	logic signed [CW:0]   d_sel;
	logic [PW-1:0]        off_abs;
	logic                 sep;
	logic signed [EW-1:0] dsum;
	logic signed [obbsa_pkg::RND_W-1:0] drnd;
	logic [obbsa_pkg::ABS_W-1:0] dabs;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign res_acc   = res_valid_q && !res_stall;
	assign res_valid = res_valid_q;
	assign overlap   = overlap_q;

	// quaternion of the box whose matrix is being built
	always_comb begin
		qw = box_q ? tq_q[0] : rq_q[0];
		qx = box_q ? tq_q[1] : rq_q[1];
		qy = box_q ? tq_q[2] : rq_q[2];
		qz = box_q ? tq_q[3] : rq_q[3];
	end

	// rotation matrix entries in Q.28 from the nine quaternion products
	// products: yy zz xx xy wz xz wy yz wx
	always_comb begin
		ent[0] = obbsa_pkg::ONE_Q28 - ((EW'(qp_q[0]) + EW'(qp_q[1])) <<< 1);
		ent[1] = (EW'(qp_q[3]) + EW'(qp_q[4])) <<< 1;
		ent[2] = (EW'(qp_q[5]) - EW'(qp_q[6])) <<< 1;
		ent[3] = (EW'(qp_q[3]) - EW'(qp_q[4])) <<< 1;
		ent[4] = obbsa_pkg::ONE_Q28 - ((EW'(qp_q[2]) + EW'(qp_q[1])) <<< 1);
		ent[5] = (EW'(qp_q[7]) + EW'(qp_q[8])) <<< 1;
		ent[6] = (EW'(qp_q[5]) + EW'(qp_q[6])) <<< 1;
		ent[7] = (EW'(qp_q[7]) - EW'(qp_q[8])) <<< 1;
		ent[8] = obbsa_pkg::ONE_Q28 - ((EW'(qp_q[2]) + EW'(qp_q[0])) <<< 1);
		ax_wr  = obbsa_pkg::clamp16(obbsa_pkg::rnd14(ent[cnt_q]));
		ax_widx = (box_q ? 5'd9 : 5'd0) + 5'(cnt_q);
	end

	// axis table read port, one address per cycle
	always_comb begin
		ax_ridx = 5'd0;
		if (state_q == S_ULD)
			ax_ridx = 5'(axis_q) * 5'd3 + 5'(cnt_q);
		else if (cnt_q < 4'd6)
			ax_ridx = 5'(cnt_q) * 5'd3 + 5'(sub_q);
		ax_rd = ax_q[ax_ridx];
	end

	// half extent and centre offset selection
	always_comb begin
		if (cnt_q < 4'd3)
			h_sel = rh_q[cnt_q[1:0]];
		else
			h_sel = th_q[2'(cnt_q - 4'd3)];
		d_sel = (CW+1)'(tc_q[cnt_q[1:0]]) - (CW+1)'(rc_q[cnt_q[1:0]]);
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		tag_in = '0;
		qa     = '0;
		qb     = '0;
		case (state_q)
			S_QP: begin
				case (cnt_q)
					4'd0: begin qa = qy; qb = qy; end
					4'd1: begin qa = qz; qb = qz; end
					4'd2: begin qa = qx; qb = qx; end
					4'd3: begin qa = qx; qb = qy; end
					4'd4: begin qa = qw; qb = qz; end
					4'd5: begin qa = qx; qb = qz; end
					4'd6: begin qa = qw; qb = qy; end
					4'd7: begin qa = qy; qb = qz; end
					4'd8: begin qa = qw; qb = qx; end
					default: begin qa = '0; qb = '0; end
				endcase
				mul_a = AW'(qa);
				mul_b = obbsa_pkg::UB_W'(qb);
				tag_in.vld  = (cnt_q < 4'd9);
				tag_in.kind = obbsa_pkg::K_QP;
				tag_in.idx  = cnt_q;
			end
			S_DOT: begin
				mul_a = AW'(ax_rd);
				mul_b = obbsa_pkg::UB_W'(u_q[sub_q]);
				tag_in.vld   = (cnt_q < 4'd6);
				tag_in.kind  = obbsa_pkg::K_DOT;
				tag_in.idx   = cnt_q;
				tag_in.first = (sub_q == 2'd0);
				tag_in.last  = (sub_q == 2'd2);
			end
			S_HALF: begin
				mul_a = AW'({1'b0, h_sel});
				mul_b = obbsa_pkg::UB_W'({1'b0, absd_q[cnt_q[2:0]]});
				tag_in.vld   = 1'b1;
				tag_in.kind  = obbsa_pkg::K_HALF;
				tag_in.idx   = cnt_q;
				tag_in.first = (cnt_q == 4'd0);
			end
			S_OFF: begin
				mul_a = AW'(d_sel);
				mul_b = obbsa_pkg::UB_W'(u_q[cnt_q[1:0]]);
				tag_in.vld   = (cnt_q < 4'd3);
				tag_in.kind  = obbsa_pkg::K_OFF;
				tag_in.idx   = cnt_q;
				tag_in.first = (cnt_q == 4'd0);
			end
			default: ;
		endcase
	end

	obbsa_mul #(
		.AW(AW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (mul_a),
		.b      (mul_b),
		.tag_in (tag_in),
		.p_s1   (p_s1),
		.tag_s1 (tag_s1)
	);

	// projection accumulate and rounding
	always_comb begin
		dsum = (tag_s1.first ? '0 : dacc_q) + p_s1[EW-1:0];
		drnd = obbsa_pkg::rnd14(dsum);
		dabs = obbsa_pkg::ABS_W'(drnd[obbsa_pkg::RND_W-1] ? -drnd : drnd);
		off_abs = off_q[PW-1] ? PW'(-off_q) : PW'(off_q);
		sep = (halves_q < off_abs);
	end

	// box registers and product writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				rc_q[i] <= '0;
				rh_q[i] <= '0;
			end
			rq_q[0] <= obbsa_pkg::AXIS_MAX;
			rq_q[1] <= '0;
			rq_q[2] <= '0;
			rq_q[3] <= '0;
		end else if (req_acc && cmd == obbsa_pkg::CMD_LOAD) begin
			rc_q[0] <= center_x;
			rc_q[1] <= center_y;
			rc_q[2] <= center_z;
			rh_q[0] <= half_x;
			rh_q[1] <= half_y;
			rh_q[2] <= half_z;
			rq_q[0] <= rot_w;
			rq_q[1] <= rot_x;
			rq_q[2] <= rot_y;
			rq_q[3] <= rot_z;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && cmd == obbsa_pkg::CMD_TEST) begin
			tc_q[0] <= center_x;
			tc_q[1] <= center_y;
			tc_q[2] <= center_z;
			th_q[0] <= half_x;
			th_q[1] <= half_y;
			th_q[2] <= half_z;
			tq_q[0] <= rot_w;
			tq_q[1] <= rot_x;
			tq_q[2] <= rot_y;
			tq_q[3] <= rot_z;
		end
		if (state_q == S_EN)
			ax_q[ax_widx] <= ax_wr;
		if (state_q == S_ULD)
			u_q[cnt_q[1:0]] <= ax_rd;
		if (tag_s1.vld) begin
			case (tag_s1.kind)
				obbsa_pkg::K_QP:   qp_q[tag_s1.idx] <= p_s1[31:0];
				obbsa_pkg::K_DOT: begin
					if (tag_s1.last)
						absd_q[tag_s1.idx[2:0]] <= dabs;
					else
						dacc_q <= dsum;
				end
				obbsa_pkg::K_HALF: halves_q <= (tag_s1.first ? '0 : halves_q) + PW'(p_s1);
				obbsa_pkg::K_OFF:  off_q <= (tag_s1.first ? '0 : off_q) + p_s1;
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sub_q       <= '0;
			box_q       <= 1'b0;
			axis_q      <= '0;
			res_valid_q <= 1'b0;
			overlap_q   <= 1'b0;
		end else begin
			// result flag: set by the final compare, cleared when taken
			if (state_q == S_CMP && (sep || axis_q == 3'd5) && (!res_valid_q || !res_stall))
				res_valid_q <= 1'b1;
			else if (res_acc)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					box_q <= 1'b0;
					if (req_acc && cmd == obbsa_pkg::CMD_TEST)
						state_q <= S_QP;
				end
				S_QP: begin
					if (cnt_q == 4'd9) begin
						cnt_q   <= '0;
						state_q <= S_EN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_EN: begin
					if (cnt_q == 4'd8) begin
						cnt_q <= '0;
						if (!box_q) begin
							box_q   <= 1'b1;
							state_q <= S_QP;
						end else begin
							axis_q  <= '0;
							state_q <= S_ULD;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_ULD: begin
					if (cnt_q == 4'd2) begin
						cnt_q   <= '0;
						sub_q   <= '0;
						state_q <= S_DOT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_DOT: begin
					if (cnt_q == 4'd6) begin
						cnt_q   <= '0;
						state_q <= S_HALF;
					end else if (sub_q == 2'd2) begin
						sub_q <= '0;
						cnt_q <= cnt_q + 4'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				S_HALF: begin
					if (cnt_q == 4'd5) begin
						cnt_q   <= '0;
						state_q <= S_OFF;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_OFF: begin
					if (cnt_q == 4'd3) begin
						cnt_q   <= '0;
						state_q <= S_CMP;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_CMP: begin
					if (sep || axis_q == 3'd5) begin
						if (!res_valid_q || !res_stall) begin
							overlap_q   <= !sep;
							state_q     <= S_IDLE;
						end
					end else begin
						axis_q  <= axis_q + 3'd1;
						cnt_q   <= '0;
						state_q <= S_ULD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a product in flight only comes from a running test
	a_tag_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.vld |-> $past(state_q != S_IDLE))
		else $error("product in flight without a running test");

	// a new result only follows the final compare
	a_res_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_CMP))
		else $error("result raised outside compare");

	// axis counter stays within the six face axes
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> axis_q <= 3'd5)
		else $error("axis counter out of range");

	// a test in progress never accepts a request
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req_acc)
		else $error("request accepted during a test");

endmodule

FILE: sv/obbsa_mul.sv
// ----------------------------------------------------------------------------
// obbsa_mul: shared signed multiplier
// One registered signed product per cycle; a tag travels alongside so the
// sequencer knows where to accumulate the result in the cycle after it is issued.
// ----------------------------------------------------------------------------
module obbsa_mul #(
	parameter int AW = 34
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [AW-1:0]                 a,
	input  logic signed [obbsa_pkg::UB_W-1:0]    b,
	input  obbsa_pkg::tag_t                      tag_in,
	output logic signed [AW+obbsa_pkg::UB_W-1:0] p_s1,
	output obbsa_pkg::tag_t                      tag_s1
);

	// tag is control, cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		p_s1 <= (AW+obbsa_pkg::UB_W)'(a) * (AW+obbsa_pkg::UB_W)'(b);
	end

endmodule

FILE: verif/obbsa_checker.sv
// ----------------------------------------------------------------------------
// obbsa_checker: overlap predictor and result scoreboard
// Watches the request and result channels, keeps its own copy of the
// reference box, predicts the overlap bit of each test and compares results
// in order.
// ----------------------------------------------------------------------------
module obbsa_checker #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic [COORD_WIDTH-2:0]        half_x,
	input  logic [COORD_WIDTH-2:0]        half_y,
	input  logic [COORD_WIDTH-2:0]        half_z,
	input  logic signed [15:0]            rot_w,
	input  logic signed [15:0]            rot_x,
	input  logic signed [15:0]            rot_y,
	input  logic signed [15:0]            rot_z,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic                          overlap,
	output int                            fail_count,
	output int                            pending
);

	typedef longint signed mat_t [3][3];

	// stored reference box
	longint signed box_c [3];
	longint signed box_h [3];
	logic signed [15:0] box_q [4];
	bit overlap_q [$];

	assign pending = overlap_q.size();

	// Q.28 -> Q.14 with round half up
	function automatic longint signed to_q14(input longint signed v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic longint signed sat_entry(input longint signed v);
		longint signed r;
		r = to_q14(v);
		if (r > 16384)
			return 16384;
		if (r < -16384)
			return -16384;
		return r;
	endfunction

	// columns of the rotation matrix, axis k in row k
	function automatic mat_t axes_of(input logic signed [15:0] q [4]);
		longint signed w, x, y, z;
		mat_t a;
		w = q[0]; x = q[1]; y = q[2]; z = q[3];
		a[0][0] = sat_entry((64'sd1 <<< 28) - 2 * (y * y + z * z));
		a[0][1] = sat_entry(2 * (x * y + w * z));
		a[0][2] = sat_entry(2 * (x * z - w * y));
		a[1][0] = sat_entry(2 * (x * y - w * z));
		a[1][1] = sat_entry((64'sd1 <<< 28) - 2 * (x * x + z * z));
		a[1][2] = sat_entry(2 * (y * z + w * x));
		a[2][0] = sat_entry(2 * (x * z + w * y));
		a[2][1] = sat_entry(2 * (y * z - w * x));
		a[2][2] = sat_entry((64'sd1 <<< 28) - 2 * (x * x + y * y));
		return a;
	endfunction

	function automatic bit boxes_overlap(input longint signed tc [3],
			input longint signed th [3], input logic signed [15:0] tq [4]);
		mat_t ax [2];
		longint signed hv [2][3];
		longint signed dv [3];
		logic [65:0] halves, off_abs;
		logic signed [65:0] off, dp;
		ax[0] = axes_of(box_q);
		ax[1] = axes_of(tq);
		for (int k = 0; k < 3; k++) begin
			hv[0][k] = box_h[k];
			hv[1][k] = th[k];
			dv[k] = tc[k] - box_c[k];
		end
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 3; j++) begin
				halves = '0;
				for (int b = 0; b < 2; b++) begin
					for (int k = 0; k < 3; k++) begin
						dp = to_q14(ax[b][k][0] * ax[i][j][0] + ax[b][k][1] * ax[i][j][1]
							+ ax[b][k][2] * ax[i][j][2]);
						if (dp < 0)
							dp = -dp;
						halves += 66'(hv[b][k]) * 66'(dp);
					end
				end
				// sum saturates at 2^64-1; keep comparison equivalent
				if (halves > 66'h0_FFFF_FFFF_FFFF_FFFF)
					halves = 66'h0_FFFF_FFFF_FFFF_FFFF;
				off = 66'(dv[0]) * 66'(ax[i][j][0]) + 66'(dv[1]) * 66'(ax[i][j][1])
					+ 66'(dv[2]) * 66'(ax[i][j][2]);
				off_abs = off < 0 ? 66'(-off) : 66'(off);
				if (halves < off_abs)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// request side: load updates the box, test queues a prediction
	always_ff @(posedge clk or negedge arst_n) begin
		longint signed tc [3];
		longint signed th [3];
		logic signed [15:0] tq [4];
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_c[i] = 0;
				box_h[i] = 0;
			end
			box_q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		end else if (req_valid && !req_stall) begin
			tc = '{center_x, center_y, center_z};
			th = '{longint'(half_x), longint'(half_y), longint'(half_z)};
			tq = '{rot_w, rot_x, rot_y, rot_z};
			if (cmd == obbsa_pkg::CMD_LOAD) begin
				box_c = tc;
				box_h = th;
				box_q = tq;
			end else begin
				overlap_q.push_back(boxes_overlap(tc, th, tq));
			end
		end
	end

	// result side: in-order compare
	always_ff @(posedge clk or negedge arst_n) begin
		bit exp_bit;
		if (!arst_n) begin
			fail_count <= 0;
		end else if (res_valid && !res_stall) begin
			if (overlap_q.size() == 0) begin
				$display("%0t: unexpected result overlap=%0d", $time, overlap);
				fail_count <= fail_count + 1;
			end else begin
				exp_bit = overlap_q.pop_front();
				if (overlap !== exp_bit) begin
					$display("%0t: overlap mismatch expected %0d actual %0d",
						$time, exp_bit, overlap);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the box overlap tester
// Loads reference boxes and issues target tests, directed corners first and
// then random boxes near each other, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int CW = 32;
	localparam int NUM_RAND = 900;
	localparam int WD_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic cmd = obbsa_pkg::CMD_LOAD;
	logic signed [CW-1:0] center_x = '0, center_y = '0, center_z = '0;
	logic [CW-2:0] half_x = '0, half_y = '0, half_z = '0;
	logic signed [15:0] rot_w = '0, rot_x = '0, rot_y = '0, rot_z = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic overlap;
	int fail_count, pending;
	int send_idle_pct = 16, recv_stall_pct = 83;
	bit hold_results = 1'b0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	obb_overlap_separating_axis #(.COORD_WIDTH(CW)) u_dut (.*);

	obbsa_checker #(.COORD_WIDTH(CW)) u_chk (.*);

	// receiver stall, random or held for a long stretch
	always @(posedge clk)
		res_stall <= hold_results || ($urandom_range(99) < recv_stall_pct);

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// offer one request and wait until it is taken
	task automatic send_box(input logic c, input logic signed [CW-1:0] cx, cy, cz,
			input logic [CW-2:0] hx, hy, hz, input logic signed [15:0] qw, qx, qy, qz);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		center_x <= cx; center_y <= cy; center_z <= cz;
		half_x <= hx; half_y <= hy; half_z <= hz;
		rot_w <= qw; rot_x <= qx; rot_y <= qy; rot_z <= qz;
		// stall depends only on registered state, so its value mid-cycle holds at the next edge
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_q();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'sd0;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [CW-1:0] rand_c();
		if ($urandom_range(9) == 0)
			return CW'($urandom);
		return CW'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	function automatic logic [CW-2:0] rand_h();
		if ($urandom_range(9) == 0)
			return (CW-1)'($urandom);
		return (CW-1)'($urandom_range(32'h0004_0000));
	endfunction

	task automatic rand_box(input logic c);
		send_box(c, rand_c(), rand_c(), rand_c(), rand_h(), rand_h(), rand_h(),
			rand_q(), rand_q(), rand_q(), rand_q());
	endtask

	// stop offering, then wait for every predicted result
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-2:0] HMAX = '1;
	localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [15:0] Q_ONE = 16'sd16384;
	localparam logic signed [15:0] Q_NEG = -16'sd16384;
	localparam logic signed [15:0] Q_ZERO = 16'sd0;
	localparam logic signed [15:0] Q_COS = 16'sd11585;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// test before any load, then corners of the fields
		send_box(obbsa_pkg::CMD_TEST, '0, '0, '0, '0, '0, '0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
		send_box(obbsa_pkg::CMD_TEST, ONE, '0, '0, '0, '0, '0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
		send_box(obbsa_pkg::CMD_LOAD, '0, '0, '0, 31'h10000, 31'h10000, 31'h10000,
			Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
		// touching faces, just apart, rotated 90 degrees about z
		send_box(obbsa_pkg::CMD_TEST, 2 * ONE, '0, '0, 31'h10000, 31'h10000, 31'h10000,
			Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
		send_box(obbsa_pkg::CMD_TEST, 2 * ONE + 1, '0, '0, 31'h10000, 31'h10000, 31'h10000,
			Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
		send_box(obbsa_pkg::CMD_TEST, '0, 2 * ONE, '0, 31'h8000, 31'h8000, 31'h8000,
			Q_COS, Q_ZERO, Q_ZERO, Q_COS);
		send_box(obbsa_pkg::CMD_TEST, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX,
			Q_ONE, Q_ONE, Q_ONE, Q_ONE);
		send_box(obbsa_pkg::CMD_TEST, CMIN, CMIN, CMIN, '0, '0, '0,
			Q_NEG, Q_NEG, Q_NEG, Q_NEG);
		send_box(obbsa_pkg::CMD_TEST, CMIN, '0, CMAX, HMAX, '0, HMAX,
			16'sh8000, 16'sd32767, 16'shFFFF, Q_ZERO);
		send_box(obbsa_pkg::CMD_LOAD, CMAX, CMIN, CMAX, HMAX, HMAX, HMAX,
			16'sd32767, 16'sh8000, 16'sd5, -16'sd7);
		send_box(obbsa_pkg::CMD_TEST, CMIN, CMAX, CMIN, HMAX, HMAX, HMAX,
			Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
		send_box(obbsa_pkg::CMD_TEST, CMIN, CMAX, CMIN, '0, '0, '0,
			Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE);
		send_box(obbsa_pkg::CMD_LOAD, CMIN, CMIN, CMIN, '0, '0, '0,
			Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO);
		send_box(obbsa_pkg::CMD_TEST, CMAX, CMAX, CMAX, 31'd1, 31'd1, 31'd1,
			Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG);
		send_box(obbsa_pkg::CMD_TEST, '1, '1, '1, 31'h5555_5555, 31'h2AAA_AAAA, 31'd1,
			16'sd100, 16'sd200, 16'sd300, 16'sd400);

		// sender pauses until all results are in
		drain();

		// long receiver hold while requests keep coming
		fork
			begin
				hold_results = 1'b1;
				repeat (1500) @(posedge clk);
				hold_results = 1'b0;
			end
			begin
				for (int i = 0; i < 20; i++)
					rand_box(i % 3 == 0 ? obbsa_pkg::CMD_LOAD : obbsa_pkg::CMD_TEST);
				req_valid <= 1'b0;
			end
		join

		// random phases: mostly tests, some reloads
		for (int i = 0; i < NUM_RAND; i++) begin
			if (i == NUM_RAND / 3) begin
				send_idle_pct = 83;
				recv_stall_pct = 16;
			end else if (i == 2 * NUM_RAND / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			rand_box($urandom_range(3) == 0 ? obbsa_pkg::CMD_LOAD : obbsa_pkg::CMD_TEST);
		end

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/obbsa_pkg.sv
sv/obbsa_mul.sv
sv/obb_overlap_separating_axis.sv
verif/obbsa_checker.sv
verif/tb.sv
